// ===== hdl/brbf_pkg.sv =====
package brbf_pkg;

  // Fixed field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned LVL_W   = 12;
  localparam int unsigned SIZE_W  = 13;

  // Header bytes of a framed put: metadata, length high, length low
  localparam int unsigned HDR_BYTES = 3;
  // Smallest ring size in use
  localparam int unsigned MIN_SIZE  = 4;
  // ring_size after reset
  localparam int unsigned RING_SIZE_RST = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_START = 3'd0,
    OP_PUT_DATA  = 3'd1,
    OP_GET       = 3'd2,
    OP_PEEK      = 3'd3,
    OP_RESET     = 3'd4
  } brbf_op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SPACE = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_SHORT    = 3'd3,
    STAT_NO_GRANT = 3'd4
  } brbf_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PEEK
  } brbf_state_e;

  // Input beat as seen on the port
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
    logic              framed;
    logic [BYTE_W-1:0] metadata;
    logic [LEN_W-1:0]  offset;
  } brbf_in_t;

  // Result beat
  typedef struct packed {
    brbf_status_e      status;
    logic [BYTE_W-1:0] read_byte;
    logic [LVL_W-1:0]  level;
    logic              last;
  } brbf_out_t;

  // Classified command held in the queue
  typedef struct packed {
    brbf_op_e          op;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
    logic              framed;
    logic [BYTE_W-1:0] metadata;
    logic [LEN_W-1:0]  offset;
  } brbf_item_t;

endpackage

// ===== hdl/brbf_front.sv =====
module brbf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  brbf_pkg::brbf_in_t  in_i,
  output logic                item_valid_o,
  output brbf_pkg::brbf_item_t item_o,
  input  logic                item_pop_i
);
  import brbf_pkg::*;

  // Two-entry command queue
  brbf_item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, push, pop;
  brbf_item_t item_new;

  assign busy   = (cnt_q == 2'd2);
  assign accept = start && !busy;
  // Undefined opcodes are dropped here and never reach the back end
  assign push   = accept && (in_i.op <= OP_RESET);
  assign pop    = item_pop_i && (cnt_q != 2'd0);

  always_comb begin
    item_new.op        = brbf_op_e'(in_i.op);
    item_new.data_byte = in_i.data_byte;
    item_new.length    = in_i.length;
    item_new.framed    = in_i.framed;
    item_new.metadata  = in_i.metadata;
    item_new.offset    = in_i.offset;
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_new;
    end
  end

  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

endmodule

// ===== hdl/brbf_back.sv =====
module brbf_back #(
  parameter int unsigned DEPTH        = 4096,
  parameter int unsigned MAX_PEEK_RUN = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  input  brbf_pkg::brbf_item_t                item_i,
  output logic                                item_pop_o,
  input  logic                                cfg_we_i,
  input  logic [brbf_pkg::SIZE_W-1:0]         cfg_data_i,
  output logic                                idle_o,
  output logic                                res_valid_o,
  output brbf_pkg::brbf_out_t                 res_o
);
  import brbf_pkg::*;

  localparam int unsigned PW  = $clog2(DEPTH);         // pointer
  localparam int unsigned SW  = $clog2(DEPTH + 1);     // size and level
  localparam int unsigned CW  = (SW > SIZE_W) ? SW : SIZE_W;
  localparam int unsigned AW  = CW + 1;                // space / peek tests
  localparam int unsigned OW  = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam int unsigned RW  = $clog2(MAX_PEEK_RUN + 1);
  localparam int unsigned RST_USED =
    (RING_SIZE_RST > DEPTH) ? DEPTH : RING_SIZE_RST;

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p,
                                              input logic [SW-1:0] s);
    logic [SW-1:0] n;
    n = SW'(p) + SW'(1);
    return (n >= s) ? '0 : n[PW-1:0];
  endfunction

  brbf_state_e       state_q, state_d;
  logic [SW-1:0]     size_q, size_d;
  logic [PW-1:0]     head_q, head_d;
  logic [PW-1:0]     tail_q, tail_d;
  logic [SW-1:0]     level_q, level_d;
  logic [LEN_W-1:0]  grant_q, grant_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              hdr_hi_q, hdr_hi_d;
  logic [PW-1:0]     paddr_q, paddr_d;
  logic [RW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              res_valid_q, res_valid_d;
  brbf_out_t         res_q, res_d;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rd_q;
  logic              wr_en, rd_en;
  logic [PW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data;

  logic              emit, emit_last;
  brbf_status_e      emit_status;
  logic [BYTE_W-1:0] emit_byte;

  logic [AW-1:0]     need, fill, sum;
  logic [OW-1:0]     start_pos;
  logic [CW-1:0]     cfg_ext;

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    head_d      = head_q;
    tail_d      = tail_q;
    level_d     = level_q;
    grant_d     = grant_q;
    len_d       = len_q;
    hdr_hi_d    = hdr_hi_q;
    paddr_d     = paddr_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = tail_q;
    wr_data     = item_i.data_byte;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    item_pop_o  = 1'b0;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = STAT_OK;
    emit_byte   = '0;

    need      = AW'(item_i.length) + (item_i.framed ? AW'(HDR_BYTES) : AW'(0));
    fill      = AW'(level_q) + need;
    sum       = AW'(item_i.length) + AW'(item_i.offset);
    start_pos = OW'(head_q) + OW'(item_i.offset);
    cfg_ext   = CW'(cfg_data_i);

    // Read data from the previous cycle leaves as a result beat
    if (pend_q) begin
      emit      = 1'b1;
      emit_byte = rd_q;
      emit_last = pend_last_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && !pend_q) begin
          item_pop_o = 1'b1;
          case (item_i.op)
            OP_PUT_START: begin
              if (fill >= AW'(size_q) - AW'(1)) begin
                emit        = 1'b1;
                emit_status = STAT_NO_SPACE;
              end else begin
                grant_d = item_i.length;
                if (item_i.framed) begin
                  wr_en    = 1'b1;
                  wr_data  = item_i.metadata;
                  tail_d   = wrap_next(tail_q, size_q);
                  level_d  = level_q + SW'(1);
                  len_d    = item_i.length;
                  hdr_hi_d = 1'b1;
                  state_d  = ST_HDR;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            OP_PUT_DATA: begin
              emit = 1'b1;
              if (grant_q == '0) begin
                emit_status = STAT_NO_GRANT;
              end else begin
                wr_en   = 1'b1;
                tail_d  = wrap_next(tail_q, size_q);
                level_d = level_q + SW'(1);
                grant_d = grant_q - LEN_W'(1);
              end
            end
            OP_GET: begin
              if (level_q == '0) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                rd_en       = 1'b1;
                head_d      = wrap_next(head_q, size_q);
                level_d     = level_q - SW'(1);
                pend_d      = 1'b1;
                pend_last_d = 1'b1;
              end
            end
            OP_PEEK: begin
              if (AW'(level_q) < sum) begin
                emit        = 1'b1;
                emit_status = STAT_SHORT;
              end else if (item_i.length == '0) begin
                emit = 1'b1;
              end else begin
                // offset < size here, so one subtract wraps the start
                if (start_pos >= OW'(size_q)) begin
                  paddr_d = PW'(start_pos - OW'(size_q));
                end else begin
                  paddr_d = PW'(start_pos);
                end
                if (item_i.length > LEN_W'(MAX_PEEK_RUN)) begin
                  cnt_d = RW'(MAX_PEEK_RUN);
                end else begin
                  cnt_d = RW'(item_i.length);
                end
                state_d = ST_PEEK;
              end
            end
            OP_RESET: begin
              head_d  = '0;
              tail_d  = '0;
              level_d = '0;
              grant_d = '0;
              emit    = 1'b1;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_HDR: begin
        wr_en   = 1'b1;
        tail_d  = wrap_next(tail_q, size_q);
        level_d = level_q + SW'(1);
        if (hdr_hi_q) begin
          wr_data  = BYTE_W'(len_q >> BYTE_W);
          hdr_hi_d = 1'b0;
        end else begin
          wr_data = len_q[BYTE_W-1:0];
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_PEEK: begin
        rd_en   = 1'b1;
        rd_addr = paddr_q;
        paddr_d = wrap_next(paddr_q, size_q);
        cnt_d   = cnt_q - RW'(1);
        pend_d  = 1'b1;
        if (cnt_q == RW'(1)) begin
          pend_last_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Size write: clamp and empty the ring
    if (cfg_we_i) begin
      if (cfg_ext < CW'(MIN_SIZE)) begin
        size_d = SW'(MIN_SIZE);
      end else if (cfg_ext > CW'(DEPTH)) begin
        size_d = SW'(DEPTH);
      end else begin
        size_d = SW'(cfg_ext);
      end
      head_d  = '0;
      tail_d  = '0;
      level_d = '0;
      grant_d = '0;
    end

    res_valid_d     = emit;
    res_d.status    = emit_status;
    res_d.read_byte = emit_byte;
    res_d.level     = LVL_W'(level_d);
    res_d.last      = emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SW'(RST_USED);
      head_q      <= '0;
      tail_q      <= '0;
      level_q     <= '0;
      grant_q     <= '0;
      hdr_hi_q    <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      level_q     <= level_d;
      grant_q     <= grant_d;
      hdr_hi_q    <= hdr_hi_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    paddr_q <= paddr_d;
    res_q   <= res_d;
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign idle_o      = (state_q == ST_IDLE) && !pend_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/byte_ring_buffer_framed_core.sv =====
// Framed byte ring buffer. Every result beat leaves through the registered result
// stage: put_start, put_data, reset and every error status go straight to it; a get
// first passes the registered read of the byte store, a framed put_start its two
// more header writes, a peek its sequencer and then one byte a cycle. One single-beat
// command a cycle while the back end is free; a get, framed put or peek occupies it.
// rst_ni clears pointers, level, grant and the queue; ring size returns to min(4096, DEPTH).
module byte_ring_buffer_framed_core #(
  parameter int unsigned DEPTH        = 4096,
  parameter int unsigned MAX_PEEK_RUN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel: beat taken when start && !busy
  input  logic                        start,
  output logic                        busy,
  input  brbf_pkg::brbf_in_t          in_i,
  // result channel: one beat per strobe, cannot be held off
  output logic                        result_strobe_o,
  output brbf_pkg::brbf_out_t         res_o,
  // ring size register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brbf_pkg::SIZE_W-1:0] cfg_data_i
);
  import brbf_pkg::*;

  logic       item_valid;
  brbf_item_t item;
  logic       item_pop;
  logic       back_idle;
  logic       cfg_we;

  // Front end: takes command beats, drops undefined opcodes, and queues
  // up to two commands so the port stays open while the back end works.
  brbf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Size writes are taken only with the queue drained and the back end idle.
  assign cfg_ready_o = !item_valid && back_idle;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Back end: pointer and level bookkeeping, byte store, header writes,
  // peek sequencer and the registered result stage.
  brbf_back #(
    .DEPTH        (DEPTH),
    .MAX_PEEK_RUN (MAX_PEEK_RUN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data_i),
    .idle_o       (back_idle),
    .res_valid_o  (result_strobe_o),
    .res_o        (res_o)
  );

endmodule
